/* design/hid_keyboard_report_remapper_macros.svh */
// Assertion macros shared by the checker of the keyboard report remapper.
// Depends on nothing; included by name where assertions are written.
`ifndef HID_KEYBOARD_REPORT_REMAPPER_MACROS_SVH
`define HID_KEYBOARD_REPORT_REMAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HKR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HKR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hkr_pkg.sv */
// Types, codes and decode functions of the keyboard report remapper.
// Has no dependencies; used by every design module but the checker.
`timescale 1ns / 1ps

package hkr_pkg;

  localparam int NUM_KEYS = 6;
  localparam int AUX_W    = 15;

  localparam logic [7:0] KEY_ESC  = 8'h29;
  localparam logic [7:0] KEY_BKSP = 8'h2A;
  localparam logic [7:0] KEY_FDEL = 8'h4C;
  localparam logic [7:0] KEY_F1   = 8'h3A;
  localparam logic [7:0] KEY_F12  = 8'h45;
  localparam logic [7:0] KEY_UP   = 8'h52;
  localparam logic [7:0] KEY_L    = 8'h0F;

  localparam logic [6:0] MIN_LEN = 7'd10;
  localparam logic [7:0] ID_OK   = 8'h01;

  localparam int ST_EJECT_BIT = 0;
  localparam int ST_FN_BIT    = 1;
  localparam int AUX_LOCK_POS = 14;

  localparam logic [7:0] MOD_CHORD_UP   = 8'h01;
  localparam logic [7:0] MOD_CHORD_LOCK = 8'h0D;

  // Offsets of the two special function keys counted from F1.
  localparam logic [3:0] FIDX_F3 = 4'd2;
  localparam logic [3:0] FIDX_F4 = 4'd3;

  typedef enum logic [1:0] {
    F4_AUX1,
    F4_AUX0,
    F4_CHORD
  } f4_layout_t;

  typedef struct packed {
    logic                      pad;
    logic [7:0]                status_byte;
    logic [NUM_KEYS-1:0][7:0]  key_slot;
    logic [7:0]                reserved_byte;
    logic [7:0]                modifiers;
    logic [7:0]                report_id;
    logic [6:0]                report_length;
  } in_item_t;

  typedef struct packed {
    logic [6:0]                pad;
    logic [AUX_W-1:0]          aux_bits;
    logic                      aux_valid;
    logic [7:0]                out_status;
    logic [NUM_KEYS-1:0][7:0]  out_key;
    logic [7:0]                out_reserved;
    logic [7:0]                out_modifiers;
    logic                      accepted;
  } out_item_t;

  typedef struct packed {
    logic       act;
    logic       esc_suppress;
    logic       fdel_map;
    f4_layout_t f4_layout;
  } lane_ctrl_t;

  typedef struct packed {
    logic [7:0]       key;
    logic [AUX_W-1:0] aux;
    logic             chord_up;
    logic             chord_lock;
    logic             has_esc;
    logic             bksp_held;
  } lane_res_t;

  typedef struct packed {
    logic             media_mode_default;
    logic             toggle_chord_seen;
    logic             escape_suppress_latch;
    logic             forward_delete_latch;
    logic [AUX_W-1:0] last_aux_bits;
  } remap_state_t;

  // Media keys come first out of reset; every latch is clear.
  localparam remap_state_t STATE_RESET = '{
    media_mode_default:    1'b1,
    toggle_chord_seen:     1'b0,
    escape_suppress_latch: 1'b0,
    forward_delete_latch:  1'b0,
    last_aux_bits:         '0
  };

  function automatic f4_layout_t f4_decode(input logic [15:0] pid);
    f4_layout_t res;
    unique case (pid) inside
      16'h022C, 16'h022D, 16'h022E, 16'h0239, 16'h023A, 16'h023B: res = F4_AUX1;
      16'h029A, 16'h029C, 16'h029F, 16'h0320, 16'h0321, 16'h0322: res = F4_AUX0;
      default:                                                    res = F4_CHORD;
    endcase
    return res;
  endfunction

  // Aux mask of a function key by its offset from F1; F3 and F4 are handled apart.
  function automatic logic [AUX_W-1:0] fkey_aux(input logic [3:0] idx);
    logic [AUX_W-1:0] one;
    logic [AUX_W-1:0] res;
    one = AUX_W'(1);
    case (idx)
      4'd0:    res = one << 5;
      4'd1:    res = one << 4;
      4'd4:    res = one << 12;
      4'd5:    res = one << 13;
      4'd6:    res = one << 6;
      4'd7:    res = one << 7;
      4'd8:    res = one << 8;
      4'd9:    res = one << 9;
      4'd10:   res = one << 11;
      4'd11:   res = one << 10;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

/* design/hkr_lane.sv */
// One key-slot lane: remaps a single usage code and reports what it found.
// Depends on hkr_pkg.
`timescale 1ns / 1ps

module hkr_lane (
  input  logic [7:0]         key,
  input  hkr_pkg::lane_ctrl_t ctrl,
  output hkr_pkg::lane_res_t  res
);

  logic       is_esc;
  logic       is_bksp;
  logic       is_fkey;
  logic [3:0] idx;

  assign is_esc   = (key == hkr_pkg::KEY_ESC);
  assign is_bksp  = (key == hkr_pkg::KEY_BKSP);
  assign is_fkey  = (key >= hkr_pkg::KEY_F1) && (key <= hkr_pkg::KEY_F12) && ctrl.act;
  assign idx      = 4'(key - hkr_pkg::KEY_F1);

  always_comb begin
    res            = '0;
    res.key        = key;
    res.has_esc    = is_esc;
    res.bksp_held  = is_bksp;
    if (is_esc) begin
      if (ctrl.esc_suppress) begin
        res.key = '0;
      end
    end else if (is_bksp) begin
      if (ctrl.fdel_map) begin
        res.key = hkr_pkg::KEY_FDEL;
      end
    end else if (is_fkey) begin
      if (idx == hkr_pkg::FIDX_F3) begin
        res.chord_up = 1'b1;
        res.key      = hkr_pkg::KEY_UP;
      end else if (idx == hkr_pkg::FIDX_F4) begin
        case (ctrl.f4_layout)
          hkr_pkg::F4_AUX1: begin
            res.aux = hkr_pkg::AUX_W'(2);
            res.key = '0;
          end
          hkr_pkg::F4_AUX0: begin
            res.aux = hkr_pkg::AUX_W'(1);
            res.key = '0;
          end
          default: begin
            res.chord_lock = 1'b1;
            res.key        = hkr_pkg::KEY_L;
          end
        endcase
      end else begin
        res.aux = hkr_pkg::fkey_aux(idx);
        res.key = '0;
      end
    end
  end

endmodule

/* design/hkr_merge.sv */
// Merging stage: folds the lane findings into one result and the next state.
// Depends on hkr_pkg.
`timescale 1ns / 1ps

module hkr_merge (
  input  hkr_pkg::in_item_t                          in_item,
  input  hkr_pkg::lane_res_t [hkr_pkg::NUM_KEYS-1:0] lanes,
  input  hkr_pkg::remap_state_t                      state,
  output hkr_pkg::out_item_t                         out_item,
  output hkr_pkg::remap_state_t                      state_next
);

  logic                      ok;
  logic                      fn;
  logic                      act;
  logic                      eject_lock;
  logic                      esc_any;
  logic                      bksp_held;
  logic                      any_up;
  logic                      any_lock;
  logic [hkr_pkg::AUX_W-1:0] aux;
  logic [7:0]                mods;
  logic [7:0]                status;

  assign ok  = (in_item.report_length >= hkr_pkg::MIN_LEN) &&
               (in_item.report_id == hkr_pkg::ID_OK);
  assign fn  = in_item.status_byte[hkr_pkg::ST_FN_BIT];
  assign act = state.media_mode_default ^ fn;
  assign eject_lock = in_item.status_byte[hkr_pkg::ST_EJECT_BIT] && act;

  always_comb begin
    esc_any   = 1'b0;
    bksp_held = 1'b0;
    any_up    = 1'b0;
    any_lock  = 1'b0;
    aux       = '0;
    for (int i = 0; i < hkr_pkg::NUM_KEYS; i++) begin
      esc_any   = esc_any   | lanes[i].has_esc;
      bksp_held = bksp_held | lanes[i].bksp_held;
      any_up    = any_up    | lanes[i].chord_up;
      any_lock  = any_lock  | lanes[i].chord_lock;
      aux       = aux       | lanes[i].aux;
    end
    if (eject_lock) begin
      aux[hkr_pkg::AUX_LOCK_POS] = 1'b1;
    end
  end

  always_comb begin
    mods = in_item.modifiers;
    if (any_up) begin
      mods = mods | hkr_pkg::MOD_CHORD_UP;
    end
    if (any_lock) begin
      mods = mods | hkr_pkg::MOD_CHORD_LOCK;
    end
    status = in_item.status_byte;
    if (eject_lock) begin
      status[hkr_pkg::ST_EJECT_BIT] = 1'b0;
    end
  end

  always_comb begin
    out_item = '0;
    state_next = state;
    if (ok) begin
      out_item.accepted      = 1'b1;
      out_item.out_modifiers = mods;
      out_item.out_reserved  = in_item.reserved_byte;
      for (int i = 0; i < hkr_pkg::NUM_KEYS; i++) begin
        out_item.out_key[i] = lanes[i].key;
      end
      out_item.out_status = status;
      if (aux != state.last_aux_bits) begin
        out_item.aux_valid = 1'b1;
        out_item.aux_bits  = aux;
      end

      // Fn+Esc flips the media default only on the first report of the chord.
      if (fn && esc_any && !state.toggle_chord_seen) begin
        state_next.media_mode_default = !state.media_mode_default;
      end
      state_next.toggle_chord_seen     = fn && esc_any;
      state_next.escape_suppress_latch = esc_any && (fn || state.escape_suppress_latch);
      state_next.forward_delete_latch  = bksp_held && (fn || state.forward_delete_latch);
      state_next.last_aux_bits         = aux;
    end
  end

endmodule

/* design/hid_keyboard_report_remapper.sv */
// Keyboard report remapper: takes one report per transaction on the slave
// stream and gives one remapped report on the master stream. A report is
// worked combinationally by six key-slot lanes and a merging stage, so a
// new transaction can be taken every clock while the output buffer is not
// full; the mode and latch state is updated as each report is taken.
// Results pass through a two-entry output buffer, which registers them and
// lets input continue while a result waits. The product id write is decoded
// to the F4 layout at once and is always taken. Depends on hkr_pkg, hkr_lane and hkr_merge.
`timescale 1ns / 1ps

module hid_keyboard_report_remapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // report_length[6:0], report_id[14:7], modifiers[22:15], reserved_byte[30:23],
  // key_slot_0..5 [78:31], status_byte[86:79], zero pad [87]
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // accepted[0], out_modifiers[8:1], out_reserved[16:9], out_key_0..5 [64:17],
  // out_status[72:65], aux_valid[73], aux_bits[88:74], zero pad [95:89]
  output logic [95:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  hkr_pkg::in_item_t                          in_item;
  hkr_pkg::out_item_t                         out_item;
  hkr_pkg::remap_state_t                      state;
  hkr_pkg::remap_state_t                      state_next;
  hkr_pkg::f4_layout_t                        f4_layout;
  hkr_pkg::lane_ctrl_t                        lane_ctrl;
  hkr_pkg::lane_res_t [hkr_pkg::NUM_KEYS-1:0] lanes;

  hkr_pkg::out_item_t outbuf [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               in_fire;
  logic               out_fire;
  logic               fn;

  assign in_item   = hkr_pkg::in_item_t'(s_tdata);
  assign cfg_ready = 1'b1;
  assign s_tready  = (count != 2'd2);
  assign m_tvalid  = (count != 2'd0);
  assign m_tdata   = outbuf[rd_ptr];
  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;

  assign fn = in_item.status_byte[hkr_pkg::ST_FN_BIT];
  always_comb begin
    lane_ctrl.act          = state.media_mode_default ^ fn;
    lane_ctrl.esc_suppress = fn || state.escape_suppress_latch;
    lane_ctrl.fdel_map     = fn || state.forward_delete_latch;
    lane_ctrl.f4_layout    = f4_layout;
  end

  for (genvar g = 0; g < hkr_pkg::NUM_KEYS; g++) begin : g_lane
    hkr_lane u_lane (
      .key  (in_item.key_slot[g]),
      .ctrl (lane_ctrl),
      .res  (lanes[g])
    );
  end

  hkr_merge u_merge (
    .in_item    (in_item),
    .lanes      (lanes),
    .state      (state),
    .out_item   (out_item),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      f4_layout <= hkr_pkg::f4_decode(16'h0000);
    end else if (cfg_valid && cfg_ready) begin
      f4_layout <= hkr_pkg::f4_decode(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hkr_pkg::STATE_RESET;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      outbuf[wr_ptr] <= out_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_fire) begin
        wr_ptr <= !wr_ptr;
      end
      if (out_fire) begin
        rd_ptr <= !rd_ptr;
      end
      if (in_fire && !out_fire) begin
        count <= count + 2'd1;
      end else if (out_fire && !in_fire) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* design/hkr_checker.sv */
// Port-level checker for the keyboard report remapper, bound to the top level.
// Depends on the assertion macros header.
`timescale 1ns / 1ps
`include "hid_keyboard_report_remapper_macros.svh"

module hkr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);

  `HKR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed or dropped")
  `HKR_ASSERT_NOW(a_reject_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[95:1] == 95'd0, "rejected report carries data")
  `HKR_ASSERT_NOW(a_aux_quiet, clk, rst, m_tvalid && !m_tdata[73], m_tdata[88:74] == 15'd0, "aux bits shown without aux_valid")
  `HKR_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[95:89] == 7'd0, "output padding not zero")
  `HKR_ASSERT_NEXT(a_no_stall_empty, clk, rst, !m_tvalid, s_tready, "input stalled with empty output buffer")

endmodule

bind hid_keyboard_report_remapper hkr_checker u_hkr_checker (.*);

/* sim/tb_hid_keyboard_report_remapper.sv */
// Self-checking testbench of the keyboard report remapper: directed reports,
// then randomised held-key sessions under random stalls on both streams.
// Depends on hkr_pkg and hid_keyboard_report_remapper.
`timescale 1ns / 1ps

module tb_hid_keyboard_report_remapper;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SHOWN_ERRORS  = 10;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  hid_keyboard_report_remapper DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Mirror of the remapper state.
  logic                media_dflt;
  logic                chord_seen;
  logic                esc_latch;
  logic                fdel_latch;
  logic [14:0]         last_aux;
  logic [15:0]         cur_pid;
  hkr_pkg::f4_layout_t f4_sel;

  hkr_pkg::out_item_t expected_reports[$];
  hkr_pkg::in_item_t  prev_report;
  logic               idle_on;
  int                 mismatch_count;
  int                 reports_sent;
  int                 reports_taken;
  int                 aux_updates;
  int                 pid_writes;
  int                 cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_reports.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Length of a pause: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (!idle_on || r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(30, 8);
  endfunction

  // Receiver back-pressure.
  initial begin
    int stall;
    m_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall = stall - 1;
      end else begin
        stall = gap_len();
        m_tready <= (stall == 0);
        if (stall > 0) begin
          stall = stall - 1;
        end
      end
    end
  end

  function automatic hkr_pkg::out_item_t predict_remap(input hkr_pkg::in_item_t r);
    hkr_pkg::out_item_t res;
    logic               fn;
    logic               act;
    logic               esc_seen;
    logic               bksp_seen;
    logic [7:0]         mods;
    logic [7:0]         st;
    logic [7:0]         k;
    logic [7:0]         idx;
    logic [14:0]        aux;
    int                 i;
    res = '0;
    if (r.report_length < hkr_pkg::MIN_LEN || r.report_id != hkr_pkg::ID_OK) begin
      return res;
    end
    fn = r.status_byte[hkr_pkg::ST_FN_BIT];
    act = media_dflt ^ fn;
    mods = r.modifiers;
    st = r.status_byte;
    aux = '0;
    esc_seen = 1'b0;
    bksp_seen = 1'b0;
    for (i = 0; i < hkr_pkg::NUM_KEYS; i++) begin
      k = r.key_slot[i];
      res.out_key[i] = k;
      if (k == hkr_pkg::KEY_ESC) begin
        esc_seen = 1'b1;
        if (fn || esc_latch) begin
          res.out_key[i] = 8'h00;
          esc_latch = 1'b1;
        end
      end else if (k == hkr_pkg::KEY_BKSP) begin
        bksp_seen = 1'b1;
        if (fn || fdel_latch) begin
          res.out_key[i] = hkr_pkg::KEY_FDEL;
          fdel_latch = 1'b1;
        end
      end else if (k >= hkr_pkg::KEY_F1 && k <= hkr_pkg::KEY_F12 && act) begin
        idx = k - hkr_pkg::KEY_F1;
        res.out_key[i] = 8'h00;
        if (idx == 8'(hkr_pkg::FIDX_F3)) begin
          mods = mods | hkr_pkg::MOD_CHORD_UP;
          res.out_key[i] = hkr_pkg::KEY_UP;
        end else if (idx == 8'(hkr_pkg::FIDX_F4)) begin
          case (f4_sel)
            hkr_pkg::F4_AUX1: aux[1] = 1'b1;
            hkr_pkg::F4_AUX0: aux[0] = 1'b1;
            default: begin
              mods = mods | hkr_pkg::MOD_CHORD_LOCK;
              res.out_key[i] = hkr_pkg::KEY_L;
            end
          endcase
        end else begin
          case (idx)
            8'd0:    aux[5] = 1'b1;
            8'd1:    aux[4] = 1'b1;
            8'd4:    aux[12] = 1'b1;
            8'd5:    aux[13] = 1'b1;
            8'd6:    aux[6] = 1'b1;
            8'd7:    aux[7] = 1'b1;
            8'd8:    aux[8] = 1'b1;
            8'd9:    aux[9] = 1'b1;
            8'd10:   aux[11] = 1'b1;
            default: aux[10] = 1'b1;
          endcase
        end
      end
    end
    if (st[hkr_pkg::ST_EJECT_BIT] && act) begin
      aux[hkr_pkg::AUX_LOCK_POS] = 1'b1;
      st[hkr_pkg::ST_EJECT_BIT] = 1'b0;
    end
    // Only the first report of a held Fn+Esc chord flips the mode.
    if (fn && esc_seen) begin
      if (!chord_seen) begin
        media_dflt = ~media_dflt;
      end
      chord_seen = 1'b1;
    end else begin
      chord_seen = 1'b0;
    end
    if (!esc_seen) begin
      esc_latch = 1'b0;
    end
    if (!bksp_seen) begin
      fdel_latch = 1'b0;
    end
    res.accepted = 1'b1;
    res.out_modifiers = mods;
    res.out_reserved = r.reserved_byte;
    res.out_status = st;
    if (aux != last_aux) begin
      last_aux = aux;
      res.aux_valid = 1'b1;
      res.aux_bits = aux;
    end
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_report(input hkr_pkg::in_item_t r);
    int gap;
    hkr_pkg::out_item_t exp_res;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= r;
    do begin
      @(posedge clk);
    end while (!s_tready);
    exp_res = predict_remap(r);
    expected_reports.push_back(exp_res);
    reports_sent++;
    if (exp_res.accepted) begin
      reports_taken++;
    end
    if (exp_res.aux_valid) begin
      aux_updates++;
    end
    prev_report = r;
    @(negedge clk);
  endtask

  // Holds input back until every result has come out, then lets the block settle.
  task automatic drain_reports();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_product_id(input logic [15:0] pid);
    drain_reports();
    cfg_valid <= 1'b1;
    cfg_data <= pid;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cur_pid = pid;
    case (cur_pid)
      16'h022C, 16'h022D, 16'h022E, 16'h0239, 16'h023A, 16'h023B:
        f4_sel = hkr_pkg::F4_AUX1;
      16'h029A, 16'h029C, 16'h029F, 16'h0320, 16'h0321, 16'h0322:
        f4_sel = hkr_pkg::F4_AUX0;
      default: f4_sel = hkr_pkg::F4_CHORD;
    endcase
    pid_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic hkr_pkg::in_item_t mk_report(input logic [7:0] mods,
                                                  input logic [7:0] k0,
                                                  input logic [7:0] k1,
                                                  input logic [7:0] k2,
                                                  input logic [7:0] k3,
                                                  input logic [7:0] k4,
                                                  input logic [7:0] k5,
                                                  input logic [7:0] st);
    hkr_pkg::in_item_t r;
    r = '0;
    r.report_length = hkr_pkg::MIN_LEN;
    r.report_id = hkr_pkg::ID_OK;
    r.modifiers = mods;
    r.reserved_byte = 8'($urandom);
    r.key_slot[0] = k0;
    r.key_slot[1] = k1;
    r.key_slot[2] = k2;
    r.key_slot[3] = k3;
    r.key_slot[4] = k4;
    r.key_slot[5] = k5;
    r.status_byte = st;
    return r;
  endfunction

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 25) begin
      return 8'h00;
    end else if (r < 37) begin
      return hkr_pkg::KEY_ESC;
    end else if (r < 49) begin
      return hkr_pkg::KEY_BKSP;
    end else if (r < 85) begin
      return hkr_pkg::KEY_F1 + 8'($urandom_range(11));
    end
    return 8'($urandom);
  endfunction

  // Mostly well-formed reports, often a small change to the previous one so that
  // keys stay held across reports; the rest is random noise.
  function automatic hkr_pkg::in_item_t random_report();
    hkr_pkg::in_item_t r;
    int i;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      r = hkr_pkg::in_item_t'(88'({$urandom, $urandom, $urandom}));
      r.pad = 1'b0;
      return r;
    end
    if (pick < 55) begin
      r = prev_report;
      r.report_length = hkr_pkg::MIN_LEN;
      r.report_id = hkr_pkg::ID_OK;
      case ($urandom_range(3))
        0: r.status_byte[hkr_pkg::ST_FN_BIT] = ~r.status_byte[hkr_pkg::ST_FN_BIT];
        1: r.key_slot[$urandom_range(hkr_pkg::NUM_KEYS - 1)] = pick_key();
        2: r.status_byte[hkr_pkg::ST_EJECT_BIT] = ~r.status_byte[hkr_pkg::ST_EJECT_BIT];
        default: r.modifiers = 8'($urandom);
      endcase
      r.reserved_byte = 8'($urandom);
    end else begin
      r = mk_report(8'($urandom), 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'($urandom));
      for (i = 0; i < hkr_pkg::NUM_KEYS; i++) begin
        r.key_slot[i] = pick_key();
      end
    end
    if ($urandom_range(9) == 0) begin
      r.report_length = 7'($urandom_range(127, 10));
    end
    return r;
  endfunction

  task automatic test_rejected_reports();
    hkr_pkg::in_item_t r;
    r = mk_report(8'hFF, hkr_pkg::KEY_F1, hkr_pkg::KEY_ESC, hkr_pkg::KEY_BKSP, 8'h00,
                  8'h00, 8'hFF, 8'hFF);
    r.report_length = 7'd0;
    send_report(r);
    r.report_length = hkr_pkg::MIN_LEN - 7'd1;
    send_report(r);
    r.report_length = hkr_pkg::MIN_LEN;
    r.report_id = 8'h00;
    send_report(r);
    r.report_id = 8'hFF;
    send_report(r);
    r = mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    r.report_length = 7'h7F;
    send_report(r);
  endtask

  task automatic test_function_keys();
    send_report(mk_report(8'h00, hkr_pkg::KEY_F1, hkr_pkg::KEY_F1 + 8'd1,
                          hkr_pkg::KEY_F1 + 8'd2, hkr_pkg::KEY_F1 + 8'd3,
                          hkr_pkg::KEY_F1 + 8'd4, hkr_pkg::KEY_F1 + 8'd5, 8'h00));
    send_report(mk_report(8'h00, hkr_pkg::KEY_F1 + 8'd6, hkr_pkg::KEY_F1 + 8'd7,
                          hkr_pkg::KEY_F1 + 8'd8, hkr_pkg::KEY_F1 + 8'd9,
                          hkr_pkg::KEY_F1 + 8'd10, hkr_pkg::KEY_F12, 8'h00));
    // The same aux usage twice in a row is not sent again.
    send_report(mk_report(8'h00, hkr_pkg::KEY_F1 + 8'd6, hkr_pkg::KEY_F1 + 8'd7,
                          hkr_pkg::KEY_F1 + 8'd8, hkr_pkg::KEY_F1 + 8'd9,
                          hkr_pkg::KEY_F1 + 8'd10, hkr_pkg::KEY_F12, 8'h00));
    send_report(mk_report(8'hFF, hkr_pkg::KEY_F1, hkr_pkg::KEY_F1 + 8'd1,
                          hkr_pkg::KEY_F1 + 8'd2, hkr_pkg::KEY_F1 + 8'd3,
                          hkr_pkg::KEY_F1 + 8'd4, hkr_pkg::KEY_F1 + 8'd5, 8'h02));
    send_report(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01));
    send_report(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03));
  endtask

  task automatic test_escape_and_delete();
    send_report(mk_report(8'h00, hkr_pkg::KEY_ESC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          8'h02));
    send_report(mk_report(8'h00, hkr_pkg::KEY_ESC, hkr_pkg::KEY_F1, 8'h00, 8'h00, 8'h00,
                          8'h00, 8'h00));
    send_report(mk_report(8'h00, 8'h00, hkr_pkg::KEY_F1, 8'h00, 8'h00, 8'h00, 8'h00,
                          8'h00));
    send_report(mk_report(8'h00, 8'h00, hkr_pkg::KEY_ESC, 8'h00, 8'h00, 8'h00, 8'h00,
                          8'h02));
    send_report(mk_report(8'h00, hkr_pkg::KEY_BKSP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          8'h02));
    send_report(mk_report(8'h00, hkr_pkg::KEY_BKSP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          8'h00));
    send_report(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, hkr_pkg::KEY_BKSP,
                          8'h00));
  endtask

  task automatic test_f4_layouts();
    write_product_id(16'h022C);
    send_report(mk_report(8'h00, hkr_pkg::KEY_F1 + 8'd3, 8'h00, 8'h00, 8'h00, 8'h00,
                          8'h00, 8'h00));
    write_product_id(16'h029A);
    send_report(mk_report(8'h00, hkr_pkg::KEY_F1 + 8'd3, 8'h00, 8'h00, 8'h00, 8'h00,
                          8'h00, 8'h00));
    write_product_id(16'hFFFF);
    send_report(mk_report(8'h00, hkr_pkg::KEY_F1 + 8'd3, 8'h00, 8'h00, 8'h00, 8'h00,
                          8'h00, 8'h00));
  endtask

  task automatic test_random_reports();
    logic [15:0] pids [8];
    int phase;
    int n;
    pids = '{16'h0000, 16'h023B, 16'h0322, 16'hFFFF, 16'h029F, 16'h022E,
             16'($urandom), 16'h0239};
    for (phase = 0; phase < 8; phase++) begin
      write_product_id(pids[phase]);
      // One phase runs both streams flat out.
      idle_on = (phase != 3);
      for (n = 0; n < 190; n++) begin
        send_report(random_report());
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] got_val);
    if (exp_val !== got_val) begin
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS) begin
        $display("%0t: %s differs, expected 0x%0h, got 0x%0h", $realtime, name, exp_val,
                 got_val);
      end
    end
  endtask

  always @(posedge clk) begin
    hkr_pkg::out_item_t got;
    hkr_pkg::out_item_t exp_res;
    int i;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS) begin
          $display("%0t: result transaction with none outstanding: 0x%0h", $realtime,
                   m_tdata);
        end
      end else begin
        exp_res = expected_reports.pop_front();
        check_field("accepted", 16'(exp_res.accepted), 16'(got.accepted));
        check_field("out_modifiers", 16'(exp_res.out_modifiers), 16'(got.out_modifiers));
        check_field("out_reserved", 16'(exp_res.out_reserved), 16'(got.out_reserved));
        for (i = 0; i < hkr_pkg::NUM_KEYS; i++) begin
          check_field($sformatf("out_key_%0d", i), 16'(exp_res.out_key[i]),
                      16'(got.out_key[i]));
        end
        check_field("out_status", 16'(exp_res.out_status), 16'(got.out_status));
        check_field("aux_valid", 16'(exp_res.aux_valid), 16'(got.aux_valid));
        check_field("aux_bits", 16'(exp_res.aux_bits), 16'(got.aux_bits));
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    media_dflt = 1'b1;
    chord_seen = 1'b0;
    esc_latch = 1'b0;
    fdel_latch = 1'b0;
    last_aux = '0;
    cur_pid = '0;
    f4_sel = hkr_pkg::F4_CHORD;
    prev_report = '0;
    idle_on = 1'b1;
    mismatch_count = 0;
    reports_sent = 0;
    reports_taken = 0;
    aux_updates = 0;
    pid_writes = 0;
    cycle_count = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_rejected_reports();
    test_function_keys();
    test_escape_and_delete();
    test_f4_layouts();
    test_random_reports();

    drain_reports();
    $display("Covered %0d reports (%0d accepted, %0d aux updates) over %0d product id settings",
             reports_sent, reports_taken, aux_updates, pid_writes);
    $display("with rejects, every function key, Esc and Backspace latches and mode toggles.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d field errors in total", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
